>>> design/mcss_pkg.sv
// ============================================================================
// mcss_pkg
// Shared constants, item kind codes and controller/datapath interface types
// for the Markov chain step sampler.
// ============================================================================
package mcss_pkg;

    // Default sizes handed to the top level parameters
    localparam int MAX_STATES_DEF = 16;
    localparam int COUNT_BITS_DEF = 32;

    // Fixed field widths
    localparam int KIND_W  = 2;
    localparam int IDX_W   = 4;
    localparam int PROB_W  = 14;
    localparam int OUT_W   = 32;
    localparam int CFG_W   = 5;

    // State count after reset, and the longest report
    localparam int STATE_COUNT_RST = 16;
    localparam int MAX_RESULTS     = 16;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STEP    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REPORT  = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic accept;    // item taken this cycle
        logic load_wr;   // write one transition entry
        logic walk;      // add one column of the current row
        logic rep_rd;    // read a report count
        logic cnt_wr;    // commit a step: count, move, emit
        logic restart;   // clear counts, set state, emit
        logic rep_out;   // emit one report result
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic cur_ok;    // current state lies inside the states in use
        logic walk_done; // column matched or row exhausted
        logic rep_last;  // report index is the final one
    } t_status;

endpackage

>>> design/mcss_ctrl.sv
// ============================================================================
// mcss_ctrl
// Sequencer: decodes the item kind and steps through the row walk, the count
// update and the report loop, issuing commands to the datapath.
// ============================================================================
module mcss_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic [mcss_pkg::KIND_W-1:0] i_kind,
    input  mcss_pkg::t_status           i_status,
    output mcss_pkg::t_cmd              o_cmd,
    output logic                        busy
);
    import mcss_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_WALK    = 3'd1;
    localparam logic [2:0] S_CNT_RD  = 3'd2;
    localparam logic [2:0] S_CNT_WR  = 3'd3;
    localparam logic [2:0] S_RESTART = 3'd4;
    localparam logic [2:0] S_REP_RD  = 3'd5;
    localparam logic [2:0] S_REP_OUT = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        o_cmd         = '0;
        o_cmd.accept  = accept;
        o_cmd.load_wr = accept && (i_kind == KIND_LOAD);
        o_cmd.walk    = (r_state == S_WALK);
        o_cmd.rep_rd  = (r_state == S_REP_RD);
        o_cmd.cnt_wr  = (r_state == S_CNT_WR);
        o_cmd.restart = (r_state == S_RESTART);
        o_cmd.rep_out = (r_state == S_REP_OUT);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_kind)
                        KIND_LOAD:    n_state = S_IDLE;
                        KIND_RESTART: n_state = S_RESTART;
                        KIND_STEP:    n_state = i_status.cur_ok ? S_WALK : S_CNT_RD;
                        KIND_REPORT:  n_state = S_REP_RD;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_WALK: begin
                if (i_status.walk_done) begin
                    n_state = S_CNT_RD;
                end
            end
            S_CNT_RD:  n_state = S_CNT_WR;
            S_CNT_WR:  n_state = S_IDLE;
            S_RESTART: n_state = S_IDLE;
            S_REP_RD:  n_state = S_REP_OUT;
            S_REP_OUT: n_state = i_status.rep_last ? S_IDLE : S_REP_RD;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> design/mcss_dpath.sv
// ============================================================================
// mcss_dpath
// Datapath: transition store, visit count memory, running sum and compare,
// step counter, state count register and the result register.
// ============================================================================
module mcss_dpath #(
    parameter int MAX_STATES = mcss_pkg::MAX_STATES_DEF,
    parameter int COUNT_BITS = mcss_pkg::COUNT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mcss_pkg::t_cmd              i_cmd,
    output mcss_pkg::t_status           o_status,
    input  logic                        i_cfg_we,
    input  logic [mcss_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic [mcss_pkg::IDX_W-1:0]  i_row,
    input  logic [mcss_pkg::IDX_W-1:0]  i_col,
    input  logic [mcss_pkg::PROB_W-1:0] i_prob,
    input  logic [mcss_pkg::PROB_W-1:0] i_draw,
    input  logic [mcss_pkg::IDX_W-1:0]  i_start_state,
    output logic                        o_valid,
    output logic [mcss_pkg::IDX_W-1:0]  o_state,
    output logic [mcss_pkg::OUT_W-1:0]  o_visits,
    output logic [mcss_pkg::OUT_W-1:0]  o_step_number,
    output logic                        o_is_last
);
    import mcss_pkg::*;

    localparam int SW     = $clog2(MAX_STATES);
    localparam int NW     = $clog2(MAX_STATES + 1);
    localparam int AW     = 2 * SW;
    localparam int SDEPTH = 2 ** AW;
    localparam int SUMW   = PROB_W + SW;
    localparam int WW     = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;
    localparam int NRST   = (STATE_COUNT_RST < MAX_STATES) ? STATE_COUNT_RST : MAX_STATES;

    function automatic logic [OUT_W-1:0] show32(input logic [COUNT_BITS-1:0] v);
        logic [WW-1:0] w;
        w = WW'(v);
        return (w > WW'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : w[OUT_W-1:0];
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + COUNT_BITS'(1);
    endfunction

    // Storage
    logic [PROB_W-1:0]     store_mem [0:SDEPTH-1];
    logic [COUNT_BITS-1:0] cnt_mem   [0:MAX_STATES-1];
    logic [MAX_STATES-1:0] r_cnt_vld;
    logic [MAX_STATES-1:0] n_cnt_vld;

    logic [NW-1:0]         r_n;
    logic [NW-1:0]         cfg_n;
    logic [PROB_W-1:0]     r_draw;
    logic [SW-1:0]         r_start;
    logic [SW-1:0]         n_start;
    logic [SW-1:0]         r_cur;
    logic [SW-1:0]         r_j;
    logic [SW-1:0]         j_inc;
    logic [SW-1:0]         r_next;
    logic [SUMW-1:0]       r_sum;
    logic [SUMW-1:0]       sum_nx;
    logic [COUNT_BITS-1:0] r_steps;
    logic [COUNT_BITS-1:0] steps_inc;
    logic [PROB_W-1:0]     r_store_rd;
    logic [AW-1:0]         store_rd_addr;
    logic [AW-1:0]         store_wr_addr;
    logic                  load_ok;
    logic [COUNT_BITS-1:0] r_cnt_rd;
    logic                  r_rd_vld;
    logic [SW-1:0]         cnt_rd_addr;
    logic [SW-1:0]         cnt_wr_addr;
    logic [COUNT_BITS-1:0] cnt_new;
    logic [COUNT_BITS-1:0] cnt_wr_data;
    logic                  hit;
    logic                  j_last;

    logic                  r_o_valid;
    logic [IDX_W-1:0]      r_o_state;
    logic [OUT_W-1:0]      r_o_visits;
    logic [OUT_W-1:0]      r_o_steps;
    logic                  r_o_last;

    // Walk arithmetic
    assign j_inc  = r_j + SW'(1);
    assign sum_nx = r_sum + SUMW'(r_store_rd);
    assign hit    = (SUMW'(r_draw) <= sum_nx);
    assign j_last = ((NW'(r_j) + NW'(1)) == r_n);

    assign o_status.cur_ok    = (NW'(r_cur) < r_n);
    assign o_status.walk_done = hit || j_last;
    assign o_status.rep_last  = j_last || (32'(r_j) == MAX_RESULTS - 1);

    // Clamp state count to 1..MAX_STATES
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_n = NW'(1);
        end else if (32'(i_cfg_data) > MAX_STATES) begin
            cfg_n = NW'(MAX_STATES);
        end else begin
            cfg_n = NW'(i_cfg_data);
        end
    end

    // Saturate restart state to n-1
    assign n_start = (32'(i_start_state) >= 32'(r_n)) ? SW'(r_n - NW'(1)) : SW'(i_start_state);

    // Transition store
    assign load_ok       = (32'(i_row) < MAX_STATES) && (32'(i_col) < MAX_STATES);
    assign store_wr_addr = {SW'(i_row), SW'(i_col)};
    assign store_rd_addr = i_cmd.walk ? {r_cur, j_inc} : {r_cur, SW'(0)};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && load_ok) begin
            store_mem[store_wr_addr] <= i_prob;
        end
        r_store_rd <= store_mem[store_rd_addr];
    end

    // Visit count memory
    assign cnt_rd_addr = i_cmd.rep_rd ? r_j : r_next;
    assign cnt_new     = r_rd_vld ? sat_inc(r_cnt_rd) : COUNT_BITS'(1);
    assign cnt_wr_addr = i_cmd.restart ? r_start : r_next;
    assign cnt_wr_data = i_cmd.restart ? COUNT_BITS'(1) : cnt_new;
    assign steps_inc   = sat_inc(r_steps);

    always_ff @(posedge i_clk) begin
        if (i_cmd.restart || i_cmd.cnt_wr) begin
            cnt_mem[cnt_wr_addr] <= cnt_wr_data;
        end
        r_cnt_rd <= cnt_mem[cnt_rd_addr];
        r_rd_vld <= r_cnt_vld[cnt_rd_addr];
    end

    always_comb begin
        n_cnt_vld = r_cnt_vld;
        if (i_cmd.restart) begin
            n_cnt_vld = '0;
            n_cnt_vld[r_start] = 1'b1;
        end else if (i_cmd.cnt_wr) begin
            n_cnt_vld[r_next] = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
            r_n       <= NW'(NRST);
            r_cur     <= '0;
            r_steps   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_cnt_vld <= n_cnt_vld;
            if (i_cfg_we) begin
                r_n <= cfg_n;
            end
            if (i_cmd.restart) begin
                r_cur   <= r_start;
                r_steps <= '0;
            end else if (i_cmd.cnt_wr) begin
                r_cur   <= r_next;
                r_steps <= steps_inc;
            end
            r_o_valid <= i_cmd.restart || i_cmd.cnt_wr || i_cmd.rep_out;
        end
    end

    // Item and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_draw  <= i_draw;
            r_start <= n_start;
            r_next  <= r_cur;
            r_j     <= '0;
            r_sum   <= '0;
        end else if (i_cmd.walk) begin
            r_sum <= sum_nx;
            r_j   <= j_inc;
            if (hit) begin
                r_next <= r_j;
            end
        end else if (i_cmd.rep_out) begin
            r_j <= j_inc;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.restart) begin
            r_o_state  <= IDX_W'(r_start);
            r_o_visits <= OUT_W'(1);
            r_o_steps  <= '0;
            r_o_last   <= 1'b1;
        end else if (i_cmd.cnt_wr) begin
            r_o_state  <= IDX_W'(r_next);
            r_o_visits <= show32(cnt_new);
            r_o_steps  <= show32(steps_inc);
            r_o_last   <= 1'b1;
        end else if (i_cmd.rep_out) begin
            r_o_state  <= IDX_W'(r_j);
            r_o_visits <= r_rd_vld ? show32(r_cnt_rd) : '0;
            r_o_steps  <= show32(r_steps);
            r_o_last   <= o_status.rep_last;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_state       = r_o_state;
    assign o_visits      = r_o_visits;
    assign o_step_number = r_o_steps;
    assign o_is_last     = r_o_last;

endmodule

>>> design/markov_chain_step_sampler.sv
// Load: no result. Restart: one result strobe.
// Step: one result strobe after a row walk of k columns (1..state count) with one
//   transition store read per cycle; no walk if the state lies outside the count.
// Report: up to 16 results, each a count memory read, then output.
// One item at a time; busy is high until the last result is registered.
// Synchronous active-low reset; the transition store is not cleared by reset.
// ============================================================================
// markov_chain_step_sampler
// Markov chain sampler: inverse-CDF step over a loaded transition table with
// saturating visit counts and a count report.
// ============================================================================
module markov_chain_step_sampler #(
    parameter int MAX_STATES = mcss_pkg::MAX_STATES_DEF,
    parameter int COUNT_BITS = mcss_pkg::COUNT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [mcss_pkg::KIND_W-1:0] i_kind,
    input  logic [mcss_pkg::IDX_W-1:0]  i_row,
    input  logic [mcss_pkg::IDX_W-1:0]  i_col,
    input  logic [mcss_pkg::PROB_W-1:0] i_prob,
    input  logic [mcss_pkg::PROB_W-1:0] i_draw,
    input  logic [mcss_pkg::IDX_W-1:0]  i_start_state,
    output logic                        o_result_valid,
    output logic [mcss_pkg::IDX_W-1:0]  o_state,
    output logic [mcss_pkg::OUT_W-1:0]  o_visits,
    output logic [mcss_pkg::OUT_W-1:0]  o_step_number,
    output logic                        o_is_last,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mcss_pkg::CFG_W-1:0]  i_cfg_state_count
);
    import mcss_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = !busy;

    mcss_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_kind   (i_kind),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    mcss_dpath #(
        .MAX_STATES (MAX_STATES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_state_count),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_prob        (i_prob),
        .i_draw        (i_draw),
        .i_start_state (i_start_state),
        .o_valid       (o_result_valid),
        .o_state       (o_state),
        .o_visits      (o_visits),
        .o_step_number (o_step_number),
        .o_is_last     (o_is_last)
    );

endmodule

>>> test/tb_markov_chain_step_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_markov_chain_step_sampler
// Self-checking bench for the Markov chain step sampler. A directed table
// covers reset, extremes, range clamping, the no-match walk and short
// reports. Random phases of loads, restarts, steps and reports follow under
// several state counts and sender gap rates. Every result is checked against
// a cycle-free model of the chain held in the bench, or against typed values.
// ----------------------------------------------------------------------------
module tb_markov_chain_step_sampler;
    import mcss_pkg::*;

    localparam int NSTATES = MAX_STATES_DEF;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [PROB_W-1:0] prob;
        logic [PROB_W-1:0] draw;
        logic [IDX_W-1:0]  start_state;
    } chain_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] state;
        logic [OUT_W-1:0] visits;
        logic [OUT_W-1:0] steps;
        logic             last;
    } chain_result_t;

    typedef struct packed {
        logic              is_cfg;
        logic [CFG_W-1:0]  cfg;
        chain_item_t       it;
        logic              typed;
        logic [IDX_W-1:0]  e_state;
        logic [OUT_W-1:0]  e_visits;
        logic [OUT_W-1:0]  e_steps;
    } plan_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [KIND_W-1:0] i_kind = '0;
    logic [IDX_W-1:0]  i_row = '0;
    logic [IDX_W-1:0]  i_col = '0;
    logic [PROB_W-1:0] i_prob = '0;
    logic [PROB_W-1:0] i_draw = '0;
    logic [IDX_W-1:0]  i_start_state = '0;
    logic              o_result_valid;
    logic [IDX_W-1:0]  o_state;
    logic [OUT_W-1:0]  o_visits;
    logic [OUT_W-1:0]  o_step_number;
    logic              o_is_last;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_state_count = CFG_W'(STATE_COUNT_RST);

    // chain model
    logic [PROB_W-1:0] prob_table [NSTATES][NSTATES];
    bit                prob_loaded [NSTATES][NSTATES];
    logic [IDX_W-1:0]  chain_state = '0;
    logic [OUT_W-1:0]  visit_cnt [NSTATES];
    logic [OUT_W-1:0]  step_cnt = '0;
    logic [CFG_W-1:0]  states_cfg = CFG_W'(STATE_COUNT_RST);

    chain_result_t fresh [MAX_RESULTS];
    int            fresh_cnt;
    chain_result_t pending_results [$];
    plan_row_t     plan [$];

    int errors = 0;
    int results_seen = 0;
    int kind_cnt [4] = '{0, 0, 0, 0};
    int cfg_writes = 0;
    int stay_steps = 0;
    int idle_pct = 0;

    markov_chain_step_sampler dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_kind            (i_kind),
        .i_row             (i_row),
        .i_col             (i_col),
        .i_prob            (i_prob),
        .i_draw            (i_draw),
        .i_start_state     (i_start_state),
        .o_result_valid    (o_result_valid),
        .o_state           (o_state),
        .o_visits          (o_visits),
        .o_step_number     (o_step_number),
        .o_is_last         (o_is_last),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_state_count (i_cfg_state_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int states_in_use();
        if (states_cfg == 0) return 1;
        if (states_cfg > NSTATES) return NSTATES;
        return int'(states_cfg);
    endfunction

    function automatic logic [OUT_W-1:0] bump(logic [OUT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic chain_item_t mk_item(logic [KIND_W-1:0] kind, int row, int col,
                                            int prob, int draw, int ss);
        chain_item_t it;
        it.kind        = kind;
        it.row         = IDX_W'(row);
        it.col         = IDX_W'(col);
        it.prob        = PROB_W'(prob);
        it.draw        = PROB_W'(draw);
        it.start_state = IDX_W'(ss);
        return it;
    endfunction

    // Compute the results of one item and advance the chain.
    task automatic advance_chain(input chain_item_t it);
        int n;
        int sum;
        int j;
        bit hit;
        logic [IDX_W-1:0] nxt;
        n = states_in_use();
        fresh_cnt = 0;
        case (it.kind)
            KIND_LOAD: begin
                prob_table[it.row][it.col] = it.prob;
                prob_loaded[it.row][it.col] = 1'b1;
            end
            KIND_RESTART: begin
                nxt = (it.start_state >= n) ? IDX_W'(n - 1) : it.start_state;
                foreach (visit_cnt[s]) visit_cnt[s] = '0;
                chain_state = nxt;
                visit_cnt[nxt] = bump('0);
                step_cnt = '0;
                fresh[0] = '{nxt, visit_cnt[nxt], step_cnt, 1'b1};
                fresh_cnt = 1;
            end
            KIND_STEP: begin
                nxt = chain_state;
                hit = 1'b0;
                sum = 0;
                if (chain_state < n) begin
                    for (j = 0; j < n && !hit; j++) begin
                        sum += prob_table[chain_state][j];
                        if (it.draw <= sum) begin
                            nxt = IDX_W'(j);
                            hit = 1'b1;
                        end
                    end
                end
                if (!hit) stay_steps++;
                chain_state = nxt;
                step_cnt = bump(step_cnt);
                visit_cnt[nxt] = bump(visit_cnt[nxt]);
                fresh[0] = '{nxt, visit_cnt[nxt], step_cnt, 1'b1};
                fresh_cnt = 1;
            end
            default: begin
                for (j = 0; j < n && j < MAX_RESULTS; j++)
                    fresh[j] = '{IDX_W'(j), visit_cnt[j], step_cnt, (j == n - 1)};
                fresh_cnt = (n > MAX_RESULTS) ? MAX_RESULTS : n;
            end
        endcase
    endtask

    // First column a step with this draw would read before it was ever loaded.
    function automatic int first_unloaded(logic [PROB_W-1:0] draw);
        int n;
        int sum;
        n = states_in_use();
        sum = 0;
        if (chain_state >= n) return -1;
        for (int j = 0; j < n; j++) begin
            if (!prob_loaded[chain_state][j]) return j;
            sum += prob_table[chain_state][j];
            if (draw <= sum) return -1;
        end
        return -1;
    endfunction

    // Present one item, hold until taken, then predict it.
    task automatic issue(input chain_item_t it);
        i_kind        <= it.kind;
        i_row         <= it.row;
        i_col         <= it.col;
        i_prob        <= it.prob;
        i_draw        <= it.draw;
        i_start_state <= it.start_state;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy);
        kind_cnt[it.kind]++;
        advance_chain(it);
    endtask

    task automatic send(input chain_item_t it);
        if ($urandom_range(1, 100) <= idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        issue(it);
        for (int k = 0; k < fresh_cnt; k++) pending_results.push_back(fresh[k]);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_state_count(input logic [CFG_W-1:0] v);
        drain();
        // a trailing load gives no result: let it retire
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        i_cfg_state_count <= v;
        i_cfg_valid       <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        states_cfg = v;
        cfg_writes++;
    endtask

    function automatic logic [PROB_W-1:0] rand_prob();
        int hi;
        hi = 15000 / states_in_use();
        if (hi > 10000) hi = 10000;
        case ($urandom_range(0, 3))
            0: return PROB_W'($urandom_range(0, 10000));
            1: return '0;
            default: return PROB_W'($urandom_range(0, hi));
        endcase
    endfunction

    function automatic int pick_idx();
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, NSTATES - 1);
        return $urandom_range(0, states_in_use() - 1);
    endfunction

    // Fill any unloaded entry on the walk first, then step.
    task automatic send_step();
        int c;
        int draw;
        case ($urandom_range(0, 7))
            0: draw = 0;
            1: draw = 9999;
            default: draw = $urandom_range(0, 9999);
        endcase
        c = first_unloaded(PROB_W'(draw));
        while (c >= 0) begin
            send(mk_item(KIND_LOAD, chain_state, c, rand_prob(),
                         $urandom_range(0, 9999), $urandom_range(0, 15)));
            c = first_unloaded(PROB_W'(draw));
        end
        send(mk_item(KIND_STEP, $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 10000), draw, $urandom_range(0, 15)));
    endtask

    function automatic logic [CFG_W-1:0] pick_state_count();
        case ($urandom_range(0, 5))
            0: return CFG_W'($urandom_range(0, 1));
            1: return CFG_W'(NSTATES);
            2: return CFG_W'($urandom_range(17, 31));
            default: return CFG_W'($urandom_range(2, 15));
        endcase
    endfunction

    task automatic plan_item(logic [KIND_W-1:0] kind, int row, int col, int prob,
                             int draw, int ss);
        plan_row_t p;
        p = '0;
        p.it = mk_item(kind, row, col, prob, draw, ss);
        plan.push_back(p);
    endtask

    // Row whose results are typed in; a report gives states 0..n-1.
    task automatic plan_check(logic [KIND_W-1:0] kind, int ss, int draw, int st,
                              int vis, int steps);
        plan_row_t p;
        p = '0;
        p.it       = mk_item(kind, 0, 0, 0, draw, ss);
        p.typed    = 1'b1;
        p.e_state  = IDX_W'(st);
        p.e_visits = OUT_W'(vis);
        p.e_steps  = OUT_W'(steps);
        plan.push_back(p);
    endtask

    task automatic plan_cfg(int v);
        plan_row_t p;
        p = '0;
        p.is_cfg = 1'b1;
        p.cfg    = CFG_W'(v);
        plan.push_back(p);
    endtask

    always @(posedge i_clk) begin : check_results
        chain_result_t want;
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: state %0d visits %0d", o_state, o_visits);
                errors++;
            end else begin
                want = pending_results.pop_front();
                results_seen++;
                if (o_state !== want.state) begin
                    $error("state: expected %0d, got %0d", want.state, o_state);
                    errors++;
                end
                if (o_visits !== want.visits) begin
                    $error("visits: expected %0d, got %0d", want.visits, o_visits);
                    errors++;
                end
                if (o_step_number !== want.steps) begin
                    $error("step_number: expected %0d, got %0d", want.steps, o_step_number);
                    errors++;
                end
                if (o_is_last !== want.last) begin
                    $error("is_last: expected %0d, got %0d", want.last, o_is_last);
                    errors++;
                end
            end
        end
    end

    initial begin : main
        int gap_plan [3];
        int sel;
        gap_plan = '{0, 50, 13};
        foreach (visit_cnt[s]) visit_cnt[s] = '0;

        plan_check(KIND_REPORT, 0, 0, 0, 0, 0);
        plan_check(KIND_RESTART, 0, 0, 0, 1, 0);
        plan_check(KIND_RESTART, 15, 0, 15, 1, 0);
        plan_item(KIND_LOAD, 15, 0, 0, 0, 0);
        plan_item(KIND_LOAD, 15, 1, 10000, 0, 0);
        plan_item(KIND_STEP, 0, 0, 0, 9999, 0);
        plan_item(KIND_LOAD, 1, 0, 8191, 0, 0);
        plan_item(KIND_STEP, 0, 0, 0, 0, 0);
        plan_item(KIND_LOAD, 0, 0, 10000, 0, 0);
        plan_item(KIND_STEP, 0, 0, 0, 8192, 0);
        plan_check(KIND_RESTART, 15, 0, 15, 1, 0);
        // current state now lies above the count: no walk, state stays
        plan_cfg(4);
        plan_check(KIND_STEP, 0, 1234, 15, 2, 1);
        plan_check(KIND_REPORT, 0, 0, 0, 0, 1);
        plan_check(KIND_RESTART, 12, 0, 3, 1, 0);
        // zero clamps to a single state
        plan_cfg(0);
        plan_check(KIND_RESTART, 9, 0, 0, 1, 0);
        plan_item(KIND_LOAD, 0, 0, 0, 0, 0);
        plan_check(KIND_STEP, 0, 5, 0, 2, 1);
        plan_check(KIND_STEP, 0, 0, 0, 3, 2);
        plan_check(KIND_REPORT, 0, 0, 0, 3, 2);
        plan_cfg(31);
        plan_item(KIND_LOAD, 0, 15, 4321, 0, 0);
        plan_item(KIND_REPORT, 0, 0, 0, 0, 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                write_state_count(plan[i].cfg);
            end else begin
                issue(plan[i].it);
                for (int k = 0; k < fresh_cnt; k++) begin
                    if (plan[i].typed) begin
                        fresh[k].state  = (plan[i].it.kind == KIND_REPORT) ?
                                          IDX_W'(k) : plan[i].e_state;
                        fresh[k].visits = plan[i].e_visits;
                        fresh[k].steps  = plan[i].e_steps;
                    end
                    pending_results.push_back(fresh[k]);
                end
            end
        end

        for (int ph = 0; ph < 9; ph++) begin
            idle_pct = gap_plan[ph % 3];
            write_state_count(pick_state_count());
            send(mk_item(KIND_RESTART, $urandom_range(0, 15), $urandom_range(0, 15),
                         $urandom_range(0, 10000), $urandom_range(0, 9999),
                         $urandom_range(0, 15)));
            for (int k = 0; k < 10; k++) begin
                // hold the sender until every result is back
                if (ph == 4 && k == 5) drain();
                sel = $urandom_range(0, 99);
                if (sel < 45) begin
                    send_step();
                end else if (sel < 70) begin
                    send(mk_item(KIND_LOAD, pick_idx(), pick_idx(), rand_prob(),
                                 $urandom_range(0, 9999), $urandom_range(0, 15)));
                end else if (sel < 82) begin
                    send(mk_item(KIND_RESTART, $urandom_range(0, 15), $urandom_range(0, 15),
                                 $urandom_range(0, 10000), $urandom_range(0, 9999),
                                 $urandom_range(0, 15)));
                end else begin
                    send(mk_item(KIND_REPORT, $urandom_range(0, 15), $urandom_range(0, 15),
                                 $urandom_range(0, 10000), $urandom_range(0, 9999),
                                 $urandom_range(0, 15)));
                end
            end
        end

        drain();
        repeat (40) @(posedge i_clk);

        $display("run: %0d loads, %0d restarts, %0d steps (%0d without a move), %0d reports",
                 kind_cnt[KIND_LOAD], kind_cnt[KIND_RESTART], kind_cnt[KIND_STEP],
                 stay_steps, kind_cnt[KIND_REPORT]);
        $display("run: %0d results checked over %0d state count settings",
                 results_seen, cfg_writes);
        if (errors == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
